@@ hdl/dvru_pkg.sv @@
// shared types and constants of the distance vector route update block
package dvru_pkg;

  localparam int MAX_ROUTERS_DEF = 16;
  localparam int FIELD_IDX_W     = 4;
  localparam int COST_W          = 16;
  localparam logic [COST_W-1:0] COST_UNREACH = '1;

  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_INDEX    = 2'd1;

  // input item kinds
  localparam logic [1:0] KIND_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] KIND_SET_LINK   = 2'd1;
  localparam logic [1:0] KIND_RECOMPUTE  = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [FIELD_IDX_W-1:0] row;
    logic [FIELD_IDX_W-1:0] column;
    logic [COST_W-1:0]      cost;
    logic                   is_neighbor;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0] destination;
    logic [COST_W-1:0]      best_cost;
    logic [FIELD_IDX_W-1:0] next_hop;
    logic                   has_route;
    logic                   entry_changed;
    logic                   any_changed;
    logic                   last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOAD_ENTRY,
    OP_SET_LINK,
    OP_RECOMPUTE
  } cmd_op_t;

  // a classified command waiting for the back end
  typedef struct packed {
    cmd_op_t                op;
    logic [FIELD_IDX_W-1:0] row;
    logic [FIELD_IDX_W-1:0] column;
    logic [COST_W-1:0]      cost;
    logic                   is_neighbor;
  } cmd_t;

endpackage

@@ hdl/dvru_front.sv @@
// front end: accepts input items, drops the ones that do nothing, queues the rest
module dvru_front #(
  parameter int MAX_ROUTERS = dvru_pkg::MAX_ROUTERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  dvru_pkg::in_item_t                 in_data,
  output logic                               in_stall,
  input  logic [$clog2(MAX_ROUTERS+1)-1:0]   cnt,
  input  logic [dvru_pkg::FIELD_IDX_W-1:0]   own_index,
  input  logic                               q_full,
  output logic                               q_push,
  output dvru_pkg::cmd_t                     q_cmd
);

  logic keep;
  logic row_ok;
  logic col_ok;
  logic own_ok;
  logic seen_r;

  assign row_ok = 32'(in_data.row) < 32'(MAX_ROUTERS);
  assign col_ok = 32'(in_data.column) < 32'(MAX_ROUTERS);
  assign own_ok = 32'(own_index) < 32'(cnt);

  always_comb begin
    keep            = 1'b0;
    q_cmd.op        = dvru_pkg::OP_LOAD_ENTRY;
    q_cmd.row       = in_data.row;
    q_cmd.column    = in_data.column;
    q_cmd.cost      = in_data.cost;
    q_cmd.is_neighbor = in_data.is_neighbor;
    unique case (in_data.kind)
      dvru_pkg::KIND_LOAD_ENTRY: begin
        keep     = row_ok && col_ok;
        q_cmd.op = dvru_pkg::OP_LOAD_ENTRY;
      end
      dvru_pkg::KIND_SET_LINK: begin
        keep     = row_ok;
        q_cmd.op = dvru_pkg::OP_SET_LINK;
      end
      dvru_pkg::KIND_RECOMPUTE: begin
        // own router outside the routers in use: nothing to do
        keep     = own_ok;
        q_cmd.op = dvru_pkg::OP_RECOMPUTE;
      end
      default: keep = 1'b0;
    endcase
  end

  // stall stays high out of reset until the queue is known empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= 1'b1;
    end
  end

  assign in_stall = q_full || !seen_r;
  assign q_push   = in_valid && !in_stall && keep;

endmodule

@@ hdl/dvru_queue.sv @@
// short command queue between front end and back end
module dvru_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dvru_pkg::cmd_t push_data,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop,
  output dvru_pkg::cmd_t pop_data
);

  localparam int QD  = dvru_pkg::QUEUE_DEPTH;
  localparam int QAW = $clog2(QD);

  dvru_pkg::cmd_t  slots_r [QD];
  logic [QAW-1:0]  wr_ptr_r;
  logic [QAW-1:0]  rd_ptr_r;
  logic [QAW:0]    fill_r;
  logic            do_push;
  logic            do_pop;

  assign full      = fill_r == (QAW+1)'(QD);
  assign pop_valid = fill_r != '0;
  assign pop_data  = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        slots_r[wr_ptr_r] <= push_data;
        wr_ptr_r <= (wr_ptr_r == QAW'(QD-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QD-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

endmodule

@@ hdl/dvru_back.sv @@
// back end: table writes and the per-destination relaxation sequencer
module dvru_back #(
  parameter int MAX_ROUTERS = dvru_pkg::MAX_ROUTERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [$clog2(MAX_ROUTERS+1)-1:0]   cnt,
  input  logic [$clog2(MAX_ROUTERS)-1:0]     own,
  input  logic                               q_valid,
  input  dvru_pkg::cmd_t                     q_cmd,
  output logic                               q_pop,
  output logic                               out_valid,
  output dvru_pkg::out_item_t                out_data,
  input  logic                               out_stall
);

  localparam int RW        = $clog2(MAX_ROUTERS);
  localparam int CW        = $clog2(MAX_ROUTERS+1);
  localparam int DW        = CW + 1;
  localparam int MAT_DEPTH = 1 << (2*RW);
  localparam int CST_W     = dvru_pkg::COST_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_OWN,
    S_DRAIN
  } state_t;

  state_t state_r;

  // memories
  logic [CST_W-1:0] mat_mem  [MAT_DEPTH];
  logic [CST_W-1:0] link_mem [MAX_ROUTERS];
  logic [RW-1:0]    hop_mem  [MAX_ROUTERS];

  logic                 mat_we;
  logic [2*RW-1:0]      mat_waddr;
  logic [CST_W-1:0]     mat_wdata;
  logic                 mat_re;
  logic [2*RW-1:0]      mat_raddr;
  logic [CST_W-1:0]     mat_q;
  logic                 link_we;
  logic [CST_W-1:0]     link_q;
  logic                 hop_we;
  logic [RW-1:0]        hop_q;

  // flags reset at once
  logic [MAX_ROUTERS-1:0] nb_r;
  logic [MAX_ROUTERS-1:0] hop_vld_r;

  // sequencer
  logic [RW-1:0]    dest_r;
  logic [RW-1:0]    n_r;
  logic             rd_v_r;
  logic             rd_nb_r;
  logic [RW-1:0]    rd_n_r;
  logic [CST_W-1:0] best_r;
  logic [RW-1:0]    hop_r;
  logic             hop_has_r;
  logic             any_r;
  logic             out_valid_r;
  dvru_pkg::out_item_t out_data_r;

  logic [CST_W:0]   sum;
  logic [CST_W-1:0] sum_sat;
  logic             changed;
  logic             out_free;
  logic [DW-1:0]    nd1;
  logic [DW-1:0]    nd;
  logic             is_last;
  logic [DW-1:0]    d0;
  logic [RW-1:0]    cmd_row;
  logic [RW-1:0]    cmd_col;

  assign cmd_row = RW'(q_cmd.row);
  assign cmd_col = RW'(q_cmd.column);

  assign sum     = {1'b0, link_q} + {1'b0, mat_q};
  assign sum_sat = sum[CST_W] ? dvru_pkg::COST_UNREACH : sum[CST_W-1:0];

  assign changed = (mat_q != best_r) || (hop_vld_r[dest_r] != hop_has_r) ||
                   (hop_has_r && (hop_q != hop_r));
  assign out_free = !out_valid_r || !out_stall;

  // next destination, skipping the own one
  assign nd1     = DW'(dest_r) + DW'(1);
  assign nd      = (nd1 == DW'(own)) ? nd1 + DW'(1) : nd1;
  assign is_last = nd >= DW'(cnt);
  assign d0      = (own == '0) ? DW'(1) : '0;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = {cmd_row, cmd_col};
    mat_wdata = q_cmd.cost;
    link_we   = 1'b0;
    hop_we    = 1'b0;
    mat_re    = 1'b0;
    mat_raddr = {n_r, dest_r};
    unique case (state_r)
      S_IDLE: begin
        mat_we  = q_valid && (q_cmd.op == dvru_pkg::OP_LOAD_ENTRY);
        link_we = q_valid && (q_cmd.op == dvru_pkg::OP_SET_LINK);
      end
      S_SCAN: begin
        mat_re = 1'b1;
      end
      S_OWN: begin
        mat_re    = 1'b1;
        mat_raddr = {own, dest_r};
      end
      S_DRAIN: begin
        mat_we    = out_free && changed;
        mat_waddr = {own, dest_r};
        mat_wdata = best_r;
        hop_we    = out_free && changed;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    if (mat_re) begin
      mat_q <= mat_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[cmd_row] <= q_cmd.cost;
    end
    if (state_r == S_SCAN) begin
      link_q <= link_mem[n_r];
    end
  end

  always_ff @(posedge clk) begin
    if (hop_we) begin
      hop_mem[dest_r] <= hop_r;
    end
    if (state_r == S_OWN) begin
      hop_q <= hop_mem[dest_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nb_r        <= '0;
      hop_vld_r   <= '0;
      rd_v_r      <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // relax with the neighbor entry that arrived this cycle
      if (rd_v_r && rd_nb_r && (sum_sat < best_r)) begin
        best_r    <= sum_sat;
        hop_r     <= rd_n_r;
        hop_has_r <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          rd_v_r <= 1'b0;
          if (q_valid) begin
            unique case (q_cmd.op)
              dvru_pkg::OP_SET_LINK: nb_r[cmd_row] <= q_cmd.is_neighbor;
              dvru_pkg::OP_RECOMPUTE: begin
                any_r     <= 1'b0;
                dest_r    <= RW'(d0);
                n_r       <= '0;
                best_r    <= dvru_pkg::COST_UNREACH;
                hop_r     <= '0;
                hop_has_r <= 1'b0;
                // a single router in use has no destinations
                if (d0 < DW'(cnt)) begin
                  state_r <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          rd_v_r  <= 1'b1;
          rd_n_r  <= n_r;
          rd_nb_r <= nb_r[n_r];
          n_r     <= n_r + 1'b1;
          if (CW'(n_r) == cnt - CW'(1)) begin
            state_r <= S_OWN;
          end
        end
        S_OWN: begin
          rd_v_r  <= 1'b0;
          state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          rd_v_r <= 1'b0;
          if (out_free) begin
            out_valid_r                <= 1'b1;
            out_data_r.destination     <= dvru_pkg::FIELD_IDX_W'(dest_r);
            out_data_r.best_cost       <= best_r;
            out_data_r.next_hop        <= hop_has_r ? dvru_pkg::FIELD_IDX_W'(hop_r) : '0;
            out_data_r.has_route       <= hop_has_r;
            out_data_r.entry_changed   <= changed;
            out_data_r.any_changed     <= is_last && (any_r || changed);
            out_data_r.last            <= is_last;
            any_r                      <= any_r || changed;
            if (changed) begin
              hop_vld_r[dest_r] <= hop_has_r;
            end
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              dest_r    <= RW'(nd);
              n_r       <= '0;
              best_r    <= dvru_pkg::COST_UNREACH;
              hop_r     <= '0;
              hop_has_r <= 1'b0;
              state_r   <= S_SCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/distance_vector_route_update.sv @@
// top level of the distance vector route update block
//
// Input channel (in_valid, in_data, in_stall) takes load items and recompute
// items; result channel (out_valid, out_data, out_stall) returns one
// transaction per destination of a recompute, the final one marked last.
// Configuration (router_count, own_index) is written on cfg_* while idle.
// A front end classifies items and drops the ones that do nothing, a
// two-entry command queue decouples it from the back end, so loads keep
// flowing in while a recompute runs, until the queue is full.
// For each destination, a recompute with N routers in use reads N matrix
// entries plus the own entry through the single read port of the matrix
// memory, then compares and writes back a changed entry.
// Reset clears the neighbor flags and next-hop valid flags at once; there is no
// clearing pass, and matrix entries are undefined until loaded. in_stall is
// high for one cycle after reset.
// A stalled result holds in the output register; the back end waits there
// with the next destination ready, and the queue keeps taking items until full.
module distance_vector_route_update #(
  parameter int MAX_ROUTERS = dvru_pkg::MAX_ROUTERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  dvru_pkg::in_item_t                in_data,
  output logic                              in_stall,
  output logic                              out_valid,
  output dvru_pkg::out_item_t               out_data,
  input  logic                              out_stall,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dvru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dvru_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int RW = $clog2(MAX_ROUTERS);
  localparam int CW = $clog2(MAX_ROUTERS+1);

  logic [dvru_pkg::CFG_DATA_W-1:0]  router_count_r;
  logic [dvru_pkg::FIELD_IDX_W-1:0] own_index_r;
  logic [CW-1:0]                    cnt;

  logic           q_push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  dvru_pkg::cmd_t push_cmd;
  dvru_pkg::cmd_t pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      router_count_r <= dvru_pkg::CFG_DATA_W'(1);
      own_index_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dvru_pkg::CFG_ROUTER_COUNT: router_count_r <= cfg_wdata;
        dvru_pkg::CFG_OWN_INDEX:    own_index_r    <= cfg_wdata[dvru_pkg::FIELD_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // counts above the table size are clamped
  assign cnt = (32'(router_count_r) > 32'(MAX_ROUTERS)) ? CW'(MAX_ROUTERS)
                                                        : CW'(router_count_r);

  dvru_front #(
    .MAX_ROUTERS(MAX_ROUTERS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cnt       (cnt),
    .own_index (own_index_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  dvru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (pop_cmd)
  );

  dvru_back #(
    .MAX_ROUTERS(MAX_ROUTERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cnt       (cnt),
    .own       (RW'(own_index_r)),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  a_any_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.any_changed |-> out_data.last)
    else $error("any_changed set on a result that is not last");

  a_no_route_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_route |->
      out_data.best_cost == dvru_pkg::COST_UNREACH && out_data.next_hop == '0)
    else $error("result without route carries a cost or next hop");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("command pushed into a full queue");

  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last && !out_data.any_changed |-> !out_data.entry_changed)
    else $error("last result changed but any_changed is clear");

endmodule
